FILE: design/wpf_pkg.sv
// Package for the waypoint path follower: item and config types,
// opcode, event, register and shared-unit codes, position step function.
// No dependencies.
`timescale 1ns / 1ps

package wpf_pkg;

    localparam int DEF_MAX_WAYPOINTS = 16;
    localparam int DEF_FRAC_BITS     = 16;
    localparam int TICK_BITS         = 16;
    localparam int TGT_W             = 5;
    localparam int ALU_STEPS         = 32;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_GONE_BACK = 2'd1;
    localparam logic [1:0] EV_LOOPED    = 2'd2;
    localparam logic [1:0] EV_ENDED     = 2'd3;

    localparam logic [2:0] REG_MAX_SPEED     = 3'd0;
    localparam logic [2:0] REG_MAX_STEERING  = 3'd1;
    localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd2;
    localparam logic [2:0] REG_PATH_LENGTH   = 3'd3;
    localparam logic [2:0] REG_GO_BACK       = 3'd4;
    localparam logic [2:0] REG_LOOP_MODE     = 3'd5;

    localparam logic [1:0] ALU_MUL  = 2'd0;
    localparam logic [1:0] ALU_SQRT = 2'd1;
    localparam logic [1:0] ALU_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         waypoint_index;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic [15:0]        tick_delta;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic [3:0]         target_index;
        logic [1:0]         path_event;
    } t_out_item;

    typedef struct packed {
        logic [30:0] max_speed;
        logic [30:0] max_steering;
        logic [30:0] arrive_radius;
        logic [4:0]  path_length;
        logic        go_back;
        logic        loop_mode;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    function automatic logic signed [31:0] wpf_advance(input logic signed [31:0] p,
                                                       input logic neg,
                                                       input logic [47:0] prod);
        logic [48:0]        rnd;
        logic [32:0]        step;
        logic signed [34:0] sum;
        rnd  = {1'b0, prod} + 49'((1 << TICK_BITS) - 1);
        step = neg ? 33'(rnd >> TICK_BITS) : 33'(prod >> TICK_BITS);
        sum  = neg ? $signed({{3{p[31]}}, p}) - $signed({2'b0, step})
                   : $signed({{3{p[31]}}, p}) + $signed({2'b0, step});
        if (sum > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (sum < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return sum[31:0];
    endfunction

endpackage

FILE: design/wpf_alu.sv
// Shared arithmetic unit: registered 32x32 multiply, bit-serial square root
// and restoring divide, one result bit per cycle. Depends on wpf_pkg.
`timescale 1ns / 1ps

module wpf_alu import wpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [31:0] i_b,
    output t_alu_stat   o_stat,
    output logic [63:0] o_res
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_op;
    logic [4:0]  r_cnt;
    logic [63:0] r_sh;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_dv;
    logic [63:0] r_res;

    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] n_rem;
    logic [31:0] n_root;

    always_comb begin
        if (r_op == ALU_SQRT) begin
            rem2  = {r_rem[33:0], r_sh[63:62]};
            trial = {2'b0, r_root, 2'b01};
        end else begin
            rem2  = {r_rem[34:0], r_sh[31]};
            trial = {4'b0, r_dv};
        end
        ge     = rem2 >= trial;
        n_rem  = ge ? rem2 - trial : rem2;
        n_root = {r_root[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_op  <= i_req.op;
                r_cnt <= '0;
                case (i_req.op)
                    ALU_MUL: begin
                        r_res  <= 64'(i_a[31:0]) * 64'(i_b);
                        r_done <= 1'b1;
                    end
                    ALU_SQRT: begin
                        r_sh   <= i_a;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_busy <= 1'b1;
                    end
                    ALU_DIV: begin
                        r_sh   <= {32'b0, i_a[31:0]};
                        r_rem  <= {4'b0, i_a[63:32]};
                        r_root <= '0;
                        r_dv   <= i_b;
                        r_busy <= 1'b1;
                    end
                    default: begin
                        r_res  <= '0;
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_sh   <= (r_op == ALU_SQRT) ? {r_sh[61:0], 2'b0} : {r_sh[62:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(ALU_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= {32'b0, n_root};
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

endmodule

FILE: design/wpf_core.sv
// Sequencer, waypoint table and motion state of the path follower.
// Drives the shared unit in wpf_alu. Depends on wpf_pkg and wpf_alu.
`timescale 1ns / 1ps

module wpf_core import wpf_pkg::*; #(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FIN    = 5'd1;
    localparam logic [4:0] S_CLAMP  = 5'd2;
    localparam logic [4:0] S_W1     = 5'd3;
    localparam logic [4:0] S_ARR    = 5'd4;
    localparam logic [4:0] S_ARRD   = 5'd5;
    localparam logic [4:0] S_W2     = 5'd6;
    localparam logic [4:0] S_SEEK   = 5'd7;
    localparam logic [4:0] S_STEER  = 5'd8;
    localparam logic [4:0] S_STCHK  = 5'd9;
    localparam logic [4:0] S_VEL    = 5'd10;
    localparam logic [4:0] S_VCHK   = 5'd11;
    localparam logic [4:0] S_ADVS   = 5'd12;
    localparam logic [4:0] S_ADVX   = 5'd13;
    localparam logic [4:0] S_ADVY   = 5'd14;
    localparam logic [4:0] S_L_CHK  = 5'd15;
    localparam logic [4:0] S_L_M1   = 5'd16;
    localparam logic [4:0] S_L_M2   = 5'd17;
    localparam logic [4:0] S_L_M3   = 5'd18;
    localparam logic [4:0] S_R_INIT = 5'd19;
    localparam logic [4:0] S_R_HALF = 5'd20;
    localparam logic [4:0] S_R_M1   = 5'd21;
    localparam logic [4:0] S_R_M2   = 5'd22;
    localparam logic [4:0] S_R_SQ   = 5'd23;
    localparam logic [4:0] S_R_MX   = 5'd24;
    localparam logic [4:0] S_R_DX   = 5'd25;
    localparam logic [4:0] S_R_MY   = 5'd26;
    localparam logic [4:0] S_R_DY   = 5'd27;

    logic signed [31:0] mem_x [MAX_WAYPOINTS];
    logic signed [31:0] mem_y [MAX_WAYPOINTS];
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;

    logic [4:0]         r_state;
    logic [4:0]         r_ret;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_velx;
    logic signed [31:0] r_vely;
    logic [TGT_W-1:0]   r_tgt;
    logic               r_back;
    logic [1:0]         r_ev;
    logic [15:0]        r_dt;
    logic signed [33:0] r_vx;
    logic signed [33:0] r_vy;
    logic [30:0]        r_m;
    logic               r_long;
    logic               r_sgnx;
    logic               r_sgny;
    logic [32:0]        r_ax;
    logic [32:0]        r_ay;
    logic [31:0]        r_len;
    logic [31:0]        r_qx;
    logic [63:0]        r_acc;
    logic               r_go;
    logic [1:0]         r_op;
    logic [63:0]        r_a;
    logic [31:0]        r_b;
    logic               r_ovalid;
    t_out_item          r_out;

    t_alu_req           alu_req;
    t_alu_stat          alu_stat;
    logic [63:0]        alu_res;

    logic [32:0]        ax_c;
    logic [32:0]        ay_c;
    logic [32:0]        m_c;
    logic [TGT_W-1:0]   len_c;
    logic [TGT_W-1:0]   adv_tgt;
    logic               adv_back;
    logic [1:0]         adv_ev;
    logic signed [6:0]  ix;
    logic signed [6:0]  ilen;
    logic               accept;
    logic               slot_ok;

    assign alu_req.start = r_go;
    assign alu_req.op    = r_op;

    wpf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_stat  (alu_stat),
        .o_res   (alu_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_ok    = int'(i_in_item.waypoint_index) < MAX_WAYPOINTS;

    assign ax_c  = r_vx[33] ? 33'(-r_vx) : 33'(r_vx);
    assign ay_c  = r_vy[33] ? 33'(-r_vy) : 33'(r_vy);
    assign m_c   = {2'b0, r_m};
    assign len_c = (int'(i_cfg.path_length) > MAX_WAYPOINTS) ? TGT_W'(MAX_WAYPOINTS)
                                                              : i_cfg.path_length;

    always_comb begin
        ilen     = $signed({2'b0, len_c});
        adv_back = r_back;
        adv_ev   = EV_NONE;
        ix       = $signed({2'b0, r_tgt}) + (r_back ? -7'sd1 : 7'sd1);
        if (ix >= ilen) begin
            if (i_cfg.go_back) begin
                adv_back = !adv_back;
                ix       = ix + (adv_back ? -7'sd1 : 7'sd1);
                adv_ev   = EV_GONE_BACK;
            end else if (i_cfg.loop_mode) begin
                ix     = 7'sd0;
                adv_ev = EV_LOOPED;
            end else begin
                ix     = ilen - 7'sd1;
                adv_ev = EV_ENDED;
            end
        end
        if (ix < 7'sd0) begin
            if (i_cfg.loop_mode) begin
                adv_back = !adv_back;
                ix       = ix + (adv_back ? -7'sd1 : 7'sd1);
                adv_ev   = EV_LOOPED;
            end else begin
                ix     = 7'sd0;
                adv_ev = EV_ENDED;
            end
        end
        if (ix < 7'sd0) begin
            ix = 7'sd0;
        end
        if (ix >= ilen) begin
            ix = ilen - 7'sd1;
        end
        adv_tgt = ix[TGT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.opcode == OP_LOAD && slot_ok) begin
            mem_x[AW'(i_in_item.waypoint_index)] <= i_in_item.value_x;
            mem_y[AW'(i_in_item.waypoint_index)] <= i_in_item.value_y;
        end
        r_wx <= mem_x[AW'(r_tgt)];
        r_wy <= mem_y[AW'(r_tgt)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_px     <= '0;
            r_py     <= '0;
            r_velx   <= '0;
            r_vely   <= '0;
            r_tgt    <= '0;
            r_back   <= 1'b0;
            r_ev     <= EV_NONE;
            r_go     <= 1'b0;
            r_op     <= ALU_MUL;
            r_long   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ev    <= EV_NONE;
                        r_dt    <= i_in_item.tick_delta;
                        r_state <= S_FIN;
                        case (i_in_item.opcode)
                            OP_SET: begin
                                r_px   <= i_in_item.value_x;
                                r_py   <= i_in_item.value_y;
                                r_velx <= '0;
                                r_vely <= '0;
                            end
                            OP_TICK: r_state <= S_CLAMP;
                            default: ;
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.position_x   <= r_px;
                        r_out.position_y   <= r_py;
                        r_out.velocity_x   <= r_velx;
                        r_out.velocity_y   <= r_vely;
                        r_out.target_index <= r_tgt[3:0];
                        r_out.path_event   <= r_ev;
                        r_ovalid           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                S_CLAMP: begin
                    if (len_c == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        if (r_tgt >= len_c) begin
                            r_tgt <= len_c - 1'b1;
                        end
                        r_state <= S_W1;
                    end
                end
                S_W1: r_state <= S_ARR;
                S_ARR: begin
                    r_vx    <= $signed({{2{r_wx[31]}}, r_wx}) - $signed({{2{r_px[31]}}, r_px});
                    r_vy    <= $signed({{2{r_wy[31]}}, r_wy}) - $signed({{2{r_py[31]}}, r_py});
                    r_m     <= i_cfg.arrive_radius;
                    r_ret   <= S_ARRD;
                    r_state <= S_L_CHK;
                end
                S_ARRD: begin
                    if (!r_long) begin
                        r_tgt  <= adv_tgt;
                        r_back <= adv_back;
                        r_ev   <= adv_ev;
                    end
                    r_state <= S_W2;
                end
                S_W2: r_state <= S_SEEK;
                S_SEEK: begin
                    r_vx    <= $signed({{2{r_wx[31]}}, r_wx}) - $signed({{2{r_px[31]}}, r_px});
                    r_vy    <= $signed({{2{r_wy[31]}}, r_wy}) - $signed({{2{r_py[31]}}, r_py});
                    r_m     <= i_cfg.max_speed;
                    r_ret   <= S_STEER;
                    r_state <= S_R_INIT;
                end
                S_STEER: begin
                    r_vx    <= r_vx - $signed({{2{r_velx[31]}}, r_velx});
                    r_vy    <= r_vy - $signed({{2{r_vely[31]}}, r_vely});
                    r_m     <= i_cfg.max_steering;
                    r_ret   <= S_STCHK;
                    r_state <= S_L_CHK;
                end
                S_STCHK: begin
                    r_ret   <= S_VEL;
                    r_state <= r_long ? S_R_INIT : S_VEL;
                end
                S_VEL: begin
                    r_vx    <= r_vx + $signed({{2{r_velx[31]}}, r_velx});
                    r_vy    <= r_vy + $signed({{2{r_vely[31]}}, r_vely});
                    r_m     <= i_cfg.max_speed;
                    r_ret   <= S_VCHK;
                    r_state <= S_L_CHK;
                end
                S_VCHK: begin
                    r_ret   <= S_ADVS;
                    r_state <= r_long ? S_R_INIT : S_ADVS;
                end
                S_ADVS: begin
                    r_velx  <= r_vx[31:0];
                    r_vely  <= r_vy[31:0];
                    r_op    <= ALU_MUL;
                    r_a     <= {32'b0, ax_c[31:0]};
                    r_b     <= {16'b0, r_dt};
                    r_go    <= 1'b1;
                    r_state <= S_ADVX;
                end
                S_ADVX: begin
                    if (alu_stat.done) begin
                        r_px    <= wpf_advance(r_px, r_velx[31], alu_res[47:0]);
                        r_op    <= ALU_MUL;
                        r_a     <= {32'b0, ay_c[31:0]};
                        r_b     <= {16'b0, r_dt};
                        r_go    <= 1'b1;
                        r_state <= S_ADVY;
                    end
                end
                S_ADVY: begin
                    if (alu_stat.done) begin
                        r_py    <= wpf_advance(r_py, r_vely[31], alu_res[47:0]);
                        r_state <= S_FIN;
                    end
                end
                S_L_CHK: begin
                    if (ax_c > m_c || ay_c > m_c) begin
                        r_long  <= 1'b1;
                        r_state <= r_ret;
                    end else begin
                        r_op    <= ALU_MUL;
                        r_a     <= {32'b0, ax_c[31:0]};
                        r_b     <= ax_c[31:0];
                        r_go    <= 1'b1;
                        r_state <= S_L_M1;
                    end
                end
                S_L_M1: begin
                    if (alu_stat.done) begin
                        r_acc   <= alu_res;
                        r_a     <= {32'b0, ay_c[31:0]};
                        r_b     <= ay_c[31:0];
                        r_go    <= 1'b1;
                        r_state <= S_L_M2;
                    end
                end
                S_L_M2: begin
                    if (alu_stat.done) begin
                        r_acc   <= r_acc + alu_res;
                        r_a     <= {33'b0, r_m};
                        r_b     <= {1'b0, r_m};
                        r_go    <= 1'b1;
                        r_state <= S_L_M3;
                    end
                end
                S_L_M3: begin
                    if (alu_stat.done) begin
                        r_long  <= r_acc > alu_res;
                        r_state <= r_ret;
                    end
                end
                S_R_INIT: begin
                    r_sgnx  <= r_vx[33];
                    r_sgny  <= r_vy[33];
                    r_ax    <= ax_c;
                    r_ay    <= ay_c;
                    r_state <= S_R_HALF;
                end
                S_R_HALF: begin
                    if (r_ax[32:31] != 2'b0 || r_ay[32:31] != 2'b0) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else begin
                        r_op    <= ALU_MUL;
                        r_a     <= {32'b0, r_ax[31:0]};
                        r_b     <= r_ax[31:0];
                        r_go    <= 1'b1;
                        r_state <= S_R_M1;
                    end
                end
                S_R_M1: begin
                    if (alu_stat.done) begin
                        r_acc   <= alu_res;
                        r_a     <= {32'b0, r_ay[31:0]};
                        r_b     <= r_ay[31:0];
                        r_go    <= 1'b1;
                        r_state <= S_R_M2;
                    end
                end
                S_R_M2: begin
                    if (alu_stat.done) begin
                        r_op    <= ALU_SQRT;
                        r_a     <= r_acc + alu_res;
                        r_go    <= 1'b1;
                        r_state <= S_R_SQ;
                    end
                end
                S_R_SQ: begin
                    if (alu_stat.done) begin
                        r_len <= alu_res[31:0];
                        if (alu_res[31:0] == 32'b0) begin
                            r_vx    <= '0;
                            r_vy    <= '0;
                            r_state <= r_ret;
                        end else begin
                            r_op    <= ALU_MUL;
                            r_a     <= {32'b0, r_ax[31:0]};
                            r_b     <= {1'b0, r_m};
                            r_go    <= 1'b1;
                            r_state <= S_R_MX;
                        end
                    end
                end
                S_R_MX: begin
                    if (alu_stat.done) begin
                        r_op    <= ALU_DIV;
                        r_a     <= alu_res;
                        r_b     <= r_len;
                        r_go    <= 1'b1;
                        r_state <= S_R_DX;
                    end
                end
                S_R_DX: begin
                    if (alu_stat.done) begin
                        r_qx    <= alu_res[31:0];
                        r_op    <= ALU_MUL;
                        r_a     <= {32'b0, r_ay[31:0]};
                        r_b     <= {1'b0, r_m};
                        r_go    <= 1'b1;
                        r_state <= S_R_MY;
                    end
                end
                S_R_MY: begin
                    if (alu_stat.done) begin
                        r_op    <= ALU_DIV;
                        r_a     <= alu_res;
                        r_b     <= r_len;
                        r_go    <= 1'b1;
                        r_state <= S_R_DY;
                    end
                end
                S_R_DY: begin
                    if (alu_stat.done) begin
                        r_vx    <= r_sgnx ? -$signed({2'b0, r_qx}) : $signed({2'b0, r_qx});
                        r_vy    <= r_sgny ? -$signed({2'b0, alu_res[31:0]})
                                          : $signed({2'b0, alu_res[31:0]});
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

FILE: design/waypoint_path_follower_top.sv
// Top level of the waypoint path follower: APB register file and core.
// Depends on wpf_pkg, wpf_core and wpf_alu.
// Load and set items finish without the shared unit; a tick runs up to three rescales
// through the shared unit, each a square root and two divides.
// Throughput: one item at a time; ready is high only while the sequencer idles.
// Reset: synchronous active-low; clears position, velocity, target, direction.
`timescale 1ns / 1ps

module waypoint_path_follower_top import wpf_pkg::*; #(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
    parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    localparam logic [30:0] ONE = 31'(64'd1 << FRAC_BITS);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed     <= ONE;
            r_cfg.max_steering  <= ONE;
            r_cfg.arrive_radius <= ONE;
            r_cfg.path_length   <= '0;
            r_cfg.go_back       <= 1'b0;
            r_cfg.loop_mode     <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MAX_SPEED:     r_cfg.max_speed     <= pwdata[30:0];
                REG_MAX_STEERING:  r_cfg.max_steering  <= pwdata[30:0];
                REG_ARRIVE_RADIUS: r_cfg.arrive_radius <= pwdata[30:0];
                REG_PATH_LENGTH:   r_cfg.path_length   <= pwdata[4:0];
                REG_GO_BACK:       r_cfg.go_back       <= pwdata[0];
                REG_LOOP_MODE:     r_cfg.loop_mode     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_SPEED:     prdata = {1'b0, r_cfg.max_speed};
            REG_MAX_STEERING:  prdata = {1'b0, r_cfg.max_steering};
            REG_ARRIVE_RADIUS: prdata = {1'b0, r_cfg.arrive_radius};
            REG_PATH_LENGTH:   prdata = {27'b0, r_cfg.path_length};
            REG_GO_BACK:       prdata = {31'b0, r_cfg.go_back};
            REG_LOOP_MODE:     prdata = {31'b0, r_cfg.loop_mode};
            default:           prdata = '0;
        endcase
    end

    wpf_core #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/wpf_checker.sv
// Port-level checks for waypoint_path_follower_top, bound to the top level.
// Depends on wpf_pkg.
`timescale 1ns / 1ps

module wpf_checker import wpf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an item was accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed or dropped");

    a_out_with_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result item appeared while the sequencer was busy");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind waypoint_path_follower_top wpf_checker u_wpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: dv/tb_waypoint_path_follower_top.sv
// Testbench for waypoint_path_follower_top: directed table, then random items
// under several idle/stall phases, checked against an in-bench steering predictor.
// Depends on wpf_pkg and the waypoint_path_follower_top RTL.
`timescale 1ns / 1ps

module tb_waypoint_path_follower_top;
    import wpf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;

    waypoint_path_follower_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // predictor state
    longint            wp_x[16];
    longint            wp_y[16];
    longint            p_x, p_y, v_x, v_y;
    int                tgt;
    bit                backward;
    longint unsigned   c_speed, c_steer, c_radius;
    int                c_len;
    bit                c_goback, c_loop;

    t_out_item         pending_q[$];
    int                n_fail;
    int                send_idle_pct;
    int                recv_stall_pct;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[waypoint_path_follower_top] ERROR");
        $finish;
    end

    function automatic longint unsigned magn(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit exceeds(longint x, longint y, longint unsigned m);
        longint unsigned ax, ay;
        ax = magn(x);
        ay = magn(y);
        if (ax > m || ay > m) return 1'b1;
        return ax * ax + ay * ay > m * m;
    endfunction

    function automatic void rescale_to(longint x, longint y, longint unsigned m,
                                       output longint ox, output longint oy);
        longint unsigned ax, ay, len;
        ax = magn(x);
        ay = magn(y);
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax >>= 1;
            ay >>= 1;
        end
        len = isqrt(ax * ax + ay * ay);
        if (len == 0) begin
            ox = 0;
            oy = 0;
            return;
        end
        ax = ax * m / len;
        ay = ay * m / len;
        ox = x < 0 ? -longint'(ax) : longint'(ax);
        oy = y < 0 ? -longint'(ay) : longint'(ay);
    endfunction

    function automatic longint move_pos(longint p, longint v, longint dt);
        longint prod, stp, r;
        prod = v * dt;
        if (prod >= 0) stp = prod >> TICK_BITS;
        else stp = -((-prod + 65535) >> TICK_BITS);
        r = p + stp;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic [1:0] steer_tick(longint dt);
        int         len, idx;
        logic [1:0] ev;
        longint     dx, dy, sx, sy;
        ev = EV_NONE;
        len = c_len > 16 ? 16 : c_len;
        if (len == 0) return ev;
        if (tgt >= len) tgt = len - 1;
        idx = tgt;
        if (!exceeds(wp_x[idx] - p_x, wp_y[idx] - p_y, c_radius)) begin
            idx += backward ? -1 : 1;
            if (idx >= len) begin
                if (c_goback) begin
                    backward = !backward;
                    idx += backward ? -1 : 1;
                    ev = EV_GONE_BACK;
                end else if (c_loop) begin
                    idx = 0;
                    ev = EV_LOOPED;
                end else begin
                    idx = len - 1;
                    ev = EV_ENDED;
                end
            end
            if (idx < 0) begin
                if (c_loop) begin
                    backward = !backward;
                    idx += backward ? -1 : 1;
                    ev = EV_LOOPED;
                end else begin
                    idx = 0;
                    ev = EV_ENDED;
                end
            end
            if (idx < 0) idx = 0;
            if (idx >= len) idx = len - 1;
            tgt = idx;
        end
        rescale_to(wp_x[tgt] - p_x, wp_y[tgt] - p_y, c_speed, dx, dy);
        sx = dx - v_x;
        sy = dy - v_y;
        if (exceeds(sx, sy, c_steer)) rescale_to(sx, sy, c_steer, sx, sy);
        v_x += sx;
        v_y += sy;
        if (exceeds(v_x, v_y, c_speed)) rescale_to(v_x, v_y, c_speed, v_x, v_y);
        p_x = move_pos(p_x, v_x, dt);
        p_y = move_pos(p_y, v_y, dt);
        return ev;
    endfunction

    function automatic t_out_item follow_step(t_in_item it);
        t_out_item r;
        r.path_event = EV_NONE;
        case (it.opcode)
            OP_LOAD: begin
                wp_x[it.waypoint_index] = longint'(it.value_x);
                wp_y[it.waypoint_index] = longint'(it.value_y);
            end
            OP_SET: begin
                p_x = longint'(it.value_x);
                p_y = longint'(it.value_y);
                v_x = 0;
                v_y = 0;
            end
            OP_TICK: r.path_event = steer_tick(longint'(it.tick_delta));
            default: ;
        endcase
        r.position_x   = p_x[31:0];
        r.position_y   = p_y[31:0];
        r.velocity_x   = v_x[31:0];
        r.velocity_y   = v_y[31:0];
        r.target_index = tgt[3:0];
        return r;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MAX_SPEED:     c_speed  = val[30:0];
            REG_MAX_STEERING:  c_steer  = val[30:0];
            REG_ARRIVE_RADIUS: c_radius = val[30:0];
            REG_PATH_LENGTH:   c_len    = val[4:0];
            REG_GO_BACK:       c_goback = val[0];
            REG_LOOP_MODE:     c_loop   = val[0];
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_item(t_in_item it, bit typed, t_out_item res);
        t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = follow_step(it);
        pending_q.push_back(typed ? res : pred);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       sel;
        sel = $urandom_range(99);
        it.opcode = sel < 10 ? OP_LOAD : sel < 18 ? OP_SET : sel < 21 ? 2'd3 : OP_TICK;
        it.waypoint_index = 4'($urandom_range(15));
        it.value_x    = rand_coord();
        it.value_y    = rand_coord();
        it.tick_delta = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16'h4000));
        return it;
    endfunction

    function automatic logic [31:0] rand_mag();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0040_0000, 32'h0000_1000);
        endcase
    endfunction

    task automatic rand_config;
        reg_write(REG_MAX_SPEED, rand_mag());
        reg_write(REG_MAX_STEERING, rand_mag());
        reg_write(REG_ARRIVE_RADIUS, rand_mag());
        reg_write(REG_PATH_LENGTH, $urandom_range(7) == 0 ? $urandom : $urandom_range(16));
        reg_write(REG_GO_BACK, $urandom);
        reg_write(REG_LOOP_MODE, $urandom);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected");
                n_fail++;
            end else begin
                want = pending_q.pop_front();
                if (o_out_item.position_x !== want.position_x) begin
                    $error("position_x exp %h got %h", want.position_x, o_out_item.position_x);
                    n_fail++;
                end
                if (o_out_item.position_y !== want.position_y) begin
                    $error("position_y exp %h got %h", want.position_y, o_out_item.position_y);
                    n_fail++;
                end
                if (o_out_item.velocity_x !== want.velocity_x) begin
                    $error("velocity_x exp %h got %h", want.velocity_x, o_out_item.velocity_x);
                    n_fail++;
                end
                if (o_out_item.velocity_y !== want.velocity_y) begin
                    $error("velocity_y exp %h got %h", want.velocity_y, o_out_item.velocity_y);
                    n_fail++;
                end
                if (o_out_item.target_index !== want.target_index) begin
                    $error("target_index exp %0d got %0d", want.target_index,
                           o_out_item.target_index);
                    n_fail++;
                end
                if (o_out_item.path_event !== want.path_event) begin
                    $error("path_event exp %0d got %0d", want.path_event,
                           o_out_item.path_event);
                    n_fail++;
                end
            end
        end
        i_out_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    function automatic t_row mk(logic [1:0] op, logic [3:0] slot, logic [31:0] vx,
                                logic [31:0] vy, logic [15:0] dt, bit typed,
                                logic [31:0] ex_px, logic [31:0] ex_py);
        t_row r;
        r.it    = '{op, slot, vx, vy, dt};
        r.typed = typed;
        r.res   = '{ex_px, ex_py, 32'd0, 32'd0, 4'd0, EV_NONE};
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_row no_path[$];
        t_in_item it;
        n_fail         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        p_x = 0; p_y = 0; v_x = 0; v_y = 0;
        tgt = 0; backward = 0;
        c_speed = 65536; c_steer = 65536; c_radius = 65536;
        c_len = 0; c_goback = 0; c_loop = 0;
        foreach (wp_x[i]) begin
            wp_x[i] = 0;
            wp_y[i] = 0;
        end
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no path loaded: ticks leave everything alone
        no_path.push_back(mk(OP_TICK, 4'd0, 0, 0, 16'hFFFF, 1, 0, 0));
        no_path.push_back(mk(OP_SET, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_TICK, 4'd0, 0, 0, 16'h0000, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_LOAD, 4'd0, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_LOAD, 4'd1, 32'h0010_0000, 0, 0, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_LOAD, 4'd2, 32'h0010_0000, 32'h0010_0000, 0, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_LOAD, 4'd3, 0, 32'h0010_0000, 0, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_LOAD, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1,
                             32'h7FFF_FFFF, 32'h8000_0000));
        no_path.push_back(mk(OP_SET, 4'd0, 0, 0, 0, 1, 0, 0));
        foreach (no_path[i]) send_item(no_path[i].it, no_path[i].typed, no_path[i].res);
        drain();

        // square path, huge radius: every tick reaches the target
        reg_write(REG_PATH_LENGTH, 32'd4);
        reg_write(REG_ARRIVE_RADIUS, 32'h7FFF_FFFF);
        reg_write(REG_MAX_SPEED, 32'h0008_0000);
        for (int k = 0; k < 5; k++) rows.push_back(mk(OP_TICK, 0, 0, 0, 16'hFFFF, 0, 0, 0));
        foreach (rows[i]) send_item(rows[i].it, 0, rows[i].res);
        drain();
        reg_write(REG_GO_BACK, 32'd1);
        foreach (rows[i]) send_item(rows[i].it, 0, rows[i].res);
        drain();
        reg_write(REG_GO_BACK, 32'd0);
        reg_write(REG_LOOP_MODE, 32'd1);
        foreach (rows[i]) send_item(rows[i].it, 0, rows[i].res);
        drain();

        // fill the whole table before anything can target it
        for (int s = 0; s < 16; s++) begin
            it = rand_item();
            it.opcode = OP_LOAD;
            it.waypoint_index = 4'(s);
            send_item(it, 0, '0);
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int blk = 0; blk < 5; blk++) begin
                rand_config();
                for (int n = 0; n < 36; n++) send_item(rand_item(), 0, '0);
                drain();
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("[waypoint_path_follower_top] OK");
        end else begin
            $display("[waypoint_path_follower_top] ERROR");
        end
        $finish;
    end

endmodule
